[hdl/pic_pkg.sv]
// ============================================================================
// pic_pkg: shared constants and types of the interrupt controller
// Register map offsets, request codes and the controller/datapath command set.
// ============================================================================
`default_nettype none

package pic_pkg;

    localparam int SOURCES_DEF = 31;
    localparam int NUM_CTX     = 2;
    localparam int SRC_W       = 5;
    localparam int PRI_W       = 3;
    localparam int DATA_W      = 32;
    localparam int OFF_W       = 26;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_LEVEL = 2'd2;

    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [25:0] PEND_ADDR = 26'h0001000;
    localparam logic [25:0] EN_ADDR   = 26'h0002000;
    localparam logic [25:0] EN_STEP   = 26'h0000080;
    localparam logic [25:0] CTX_ADDR  = 26'h0200000;
    localparam logic [25:0] CTX_STEP  = 26'h0001000;
    localparam logic [25:0] CLM_DELTA = 26'h0000004;

    localparam logic [PRI_W-1:0] PRI_MASK = 3'h7;

    // controller -> datapath commands
    typedef struct packed {
        logic load;       // capture request word
        logic execute;    // perform register access / level change
        logic scan_clear; // reset scan accumulators
        logic scan_step;  // examine one source
        logic finish;     // latch irq outputs into result
    } pic_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic scan_last;  // current scan index is the final source
        logic need_claim_scan; // request is a claim read, needs best id first
    } pic_status_t;

endpackage : pic_pkg

`default_nettype wire

[hdl/pic_datapath.sv]
// ============================================================================
// pic_datapath: register file, serial best-source scan and result word
// One source is examined per scan step for both contexts at once.
// ============================================================================
`default_nettype none

module pic_datapath #(
    parameter int SOURCES = pic_pkg::SOURCES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pic_pkg::pic_cmd_t      cmd,
    output pic_pkg::pic_status_t        status,
    input  wire logic [1:0]             req_type,
    input  wire logic [25:0]            offset,
    input  wire logic [1:0]             access_size,
    input  wire logic [31:0]            write_data,
    input  wire logic [4:0]             source_id,
    input  wire logic                   level,
    output logic [31:0]                 res_read_data,
    output logic                        res_bus_fault,
    output logic                        res_machine_irq,
    output logic                        res_supervisor_irq
);

    localparam int SLOTS = SOURCES + 1;
    localparam int WORDS = (SOURCES + 32) / 32;
    localparam int IDW   = $clog2(SLOTS);
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [pic_pkg::PRI_W-1:0] pri_reg [SLOTS];
    logic [SLOTS-1:0]          pend_reg;
    logic [SLOTS-1:0]          lvl_reg;
    logic [SLOTS-1:0]          en_reg   [pic_pkg::NUM_CTX];
    logic [pic_pkg::PRI_W-1:0] thr_reg  [pic_pkg::NUM_CTX];
    logic [IDW-1:0]            clm_reg  [pic_pkg::NUM_CTX];

    logic [1:0]  rq_reg;
    logic [25:0] off_reg;
    logic [1:0]  sz_reg;
    logic [31:0] wd_reg;
    logic [4:0]  sid_reg;
    logic        lv_reg;

    logic [IDW-1:0]            idx_reg;
    logic [IDW-1:0]            best_reg [pic_pkg::NUM_CTX];
    logic [pic_pkg::PRI_W-1:0] bpri_reg [pic_pkg::NUM_CTX];

    // decode
    logic        fault;
    logic        is_bus;
    logic        is_wr;
    logic        hit_pri;
    logic        hit_pend;
    logic [1:0]  hit_en;
    logic [1:0]  hit_thr;
    logic [1:0]  hit_clm;
    logic [23:0] widx;
    logic [IDW-1:0] pidx;
    logic [25:0] eoff [pic_pkg::NUM_CTX];
    logic [31:0] rdata;
    logic [IDW-1:0] sidx;

    function automatic logic [31:0] word_of(input logic [SLOTS-1:0] v, input logic [WW-1:0] w);
        logic [WORDS*32-1:0] ext;
        ext = (WORDS*32)'(v);
        return ext[32*w +: 32];
    endfunction

    always_comb
    begin
        is_bus = (rq_reg == pic_pkg::REQ_READ) || (rq_reg == pic_pkg::REQ_WRITE);
        is_wr  = (rq_reg == pic_pkg::REQ_WRITE);
        fault  = is_bus && ((sz_reg != pic_pkg::SIZE_WORD) || (off_reg[1:0] != 2'b00));
        hit_pri  = (off_reg < 26'(SLOTS * 4));
        pidx     = IDW'(off_reg[25:2]);
        hit_pend = (off_reg >= pic_pkg::PEND_ADDR)
                && (off_reg < pic_pkg::PEND_ADDR + 26'(WORDS * 4));
        widx     = off_reg[25:2] - pic_pkg::PEND_ADDR[25:2];
        for (int c = 0; c < pic_pkg::NUM_CTX; c++)
        begin
            eoff[c] = off_reg - (pic_pkg::EN_ADDR + 26'(c) * pic_pkg::EN_STEP);
            hit_en[c] = (off_reg >= pic_pkg::EN_ADDR + 26'(c) * pic_pkg::EN_STEP)
                     && (eoff[c] < 26'(WORDS * 4));
            hit_thr[c] = off_reg == pic_pkg::CTX_ADDR + 26'(c) * pic_pkg::CTX_STEP;
            hit_clm[c] = off_reg == pic_pkg::CTX_ADDR + 26'(c) * pic_pkg::CTX_STEP
                                    + pic_pkg::CLM_DELTA;
        end
    end

    always_comb
    begin
        rdata = '0;
        if (hit_pri)
            rdata = 32'(pri_reg[pidx]);
        else if (hit_pend)
            rdata = word_of(pend_reg, WW'(widx));
        else if (hit_en[0])
            rdata = word_of(en_reg[0], WW'(eoff[0][25:2]));
        else if (hit_thr[0])
            rdata = 32'(thr_reg[0]);
        else if (hit_clm[0])
            rdata = 32'(best_reg[0]);
        else if (hit_en[1])
            rdata = word_of(en_reg[1], WW'(eoff[1][25:2]));
        else if (hit_thr[1])
            rdata = 32'(thr_reg[1]);
        else if (hit_clm[1])
            rdata = 32'(best_reg[1]);
    end

    // claim read needs the best id, so a scan runs before the access
    assign status.need_claim_scan = is_bus && !fault && !is_wr && !hit_pri && !hit_pend
                                  && ((!hit_en[0] && !hit_thr[0] && hit_clm[0])
                                   || (!hit_en[0] && !hit_thr[0] && !hit_clm[0]
                                       && !hit_en[1] && !hit_thr[1] && hit_clm[1]));
    assign status.scan_last = (idx_reg == IDW'(SOURCES));

    always_comb
    begin
        sidx = IDW'(sid_reg);
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rq_reg  <= req_type;
            off_reg <= offset;
            sz_reg  <= access_size;
            wd_reg  <= write_data;
            sid_reg <= source_id;
            lv_reg  <= level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
                pri_reg[s] <= '0;
            pend_reg <= '0;
            lvl_reg  <= '0;
            for (int c = 0; c < pic_pkg::NUM_CTX; c++)
            begin
                en_reg[c]   <= '0;
                thr_reg[c]  <= '0;
                clm_reg[c]  <= '0;
                best_reg[c] <= '0;
                bpri_reg[c] <= '0;
            end
            idx_reg <= '0;
            res_read_data      <= '0;
            res_bus_fault      <= 1'b0;
            res_machine_irq    <= 1'b0;
            res_supervisor_irq <= 1'b0;
        end
        else
        begin
            if (cmd.execute)
            begin
                res_read_data <= (is_bus && !fault && !is_wr) ? rdata : 32'd0;
                res_bus_fault <= fault;
                if (rq_reg == pic_pkg::REQ_LEVEL)
                begin
                    if (sid_reg != 5'd0 && 32'(sid_reg) <= 32'(SOURCES))
                    begin
                        lvl_reg[sidx] <= lv_reg;
                        if (lv_reg && !lvl_reg[sidx] && clm_reg[0] != sidx
                            && clm_reg[1] != sidx)
                            pend_reg[sidx] <= 1'b1;
                    end
                end
                else if (is_bus && !fault && is_wr)
                begin
                    if (hit_pri)
                    begin
                        if (pidx != '0)
                            pri_reg[pidx] <= wd_reg[pic_pkg::PRI_W-1:0] & pic_pkg::PRI_MASK;
                    end
                    else if (!hit_pend)
                    begin
                        priority if (hit_en[0])
                        begin
                            for (int b = 1; b < SLOTS; b++)
                                if (WW'(b / 32) == WW'(eoff[0][25:2]))
                                    en_reg[0][b] <= wd_reg[b % 32];
                        end
                        else if (hit_thr[0])
                            thr_reg[0] <= wd_reg[pic_pkg::PRI_W-1:0];
                        else if (hit_clm[0])
                        begin
                            if (wd_reg != 32'd0 && wd_reg <= 32'(SOURCES)
                                && 32'(clm_reg[0]) == wd_reg)
                            begin
                                clm_reg[0] <= '0;
                                if (lvl_reg[IDW'(wd_reg)])
                                    pend_reg[IDW'(wd_reg)] <= 1'b1;
                            end
                        end
                        else if (hit_en[1])
                        begin
                            for (int b = 1; b < SLOTS; b++)
                                if (WW'(b / 32) == WW'(eoff[1][25:2]))
                                    en_reg[1][b] <= wd_reg[b % 32];
                        end
                        else if (hit_thr[1])
                            thr_reg[1] <= wd_reg[pic_pkg::PRI_W-1:0];
                        else if (hit_clm[1])
                        begin
                            if (wd_reg != 32'd0 && wd_reg <= 32'(SOURCES)
                                && 32'(clm_reg[1]) == wd_reg)
                            begin
                                clm_reg[1] <= '0;
                                if (lvl_reg[IDW'(wd_reg)])
                                    pend_reg[IDW'(wd_reg)] <= 1'b1;
                            end
                        end
                    end
                end
                else if (status.need_claim_scan)
                begin
                    for (int c = 0; c < pic_pkg::NUM_CTX; c++)
                        if (hit_clm[c] && (c == 0 || !hit_clm[0]) && best_reg[c] != '0)
                        begin
                            pend_reg[best_reg[c]] <= 1'b0;
                            clm_reg[c] <= best_reg[c];
                        end
                end
            end
            if (cmd.scan_clear)
            begin
                idx_reg <= IDW'(1);
                for (int c = 0; c < pic_pkg::NUM_CTX; c++)
                begin
                    best_reg[c] <= '0;
                    bpri_reg[c] <= '0;
                end
            end
            else if (cmd.scan_step)
            begin
                for (int c = 0; c < pic_pkg::NUM_CTX; c++)
                    if (pend_reg[idx_reg] && en_reg[c][idx_reg]
                        && pri_reg[idx_reg] > thr_reg[c] && pri_reg[idx_reg] > bpri_reg[c])
                    begin
                        best_reg[c] <= idx_reg;
                        bpri_reg[c] <= pri_reg[idx_reg];
                    end
                if (!status.scan_last)
                    idx_reg <= idx_reg + IDW'(1);
            end
            if (cmd.finish)
            begin
                res_machine_irq    <= best_reg[0] != '0;
                res_supervisor_irq <= best_reg[1] != '0;
            end
        end
    end

endmodule : pic_datapath

`default_nettype wire

[hdl/pic_ctrl.sv]
// ============================================================================
// pic_ctrl: sequencer for load, optional pre-scan, access, scan, deliver
// Owns both handshakes; issues commands to the datapath.
// ============================================================================
`default_nettype none

module pic_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output pic_pkg::pic_cmd_t         cmd,
    input  wire pic_pkg::pic_status_t status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DEC   = 3'd1;
    localparam logic [2:0] ST_PRE   = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_CLR   = 3'd4;
    localparam logic [2:0] ST_SCAN  = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       accept;

    // one word in flight; next accepted once back in idle after its result is taken
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                    state_next = ST_DEC;
            end
            ST_DEC:
            begin
                cmd.scan_clear = 1'b1;
                state_next = status.need_claim_scan ? ST_PRE : ST_EXEC;
            end
            ST_PRE:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next = ST_CLR;
            end
            ST_CLR:
            begin
                cmd.scan_clear = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule : pic_ctrl

`default_nettype wire

[hdl/platform_interrupt_controller_top.sv]
// ============================================================================
// platform_interrupt_controller_top: two-context platform interrupt controller
// Bus register accesses and source level changes in, one result word out.
// ============================================================================
// Sequence: every word is loaded, accessed and then scanned over all sources;
//   a claim read first scans for the best id before its access.
// Throughput: one word at a time; the next is taken the cycle after the
//   result is taken. The serial source scan (one source per cycle) sets this.
// Reset: rst_n asynchronous, active low; clears all priorities, pending,
//   enables, thresholds, claims and levels. No clearing pass.
`default_nettype none

module platform_interrupt_controller_top #(
    parameter int SOURCES = pic_pkg::SOURCES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [25:0] offset,
    input  wire logic [1:0]  access_size,
    input  wire logic [31:0] write_data,
    input  wire logic [4:0]  source_id,
    input  wire logic        level,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      read_data,
    output logic             bus_fault,
    output logic             machine_irq,
    output logic             supervisor_irq
);

    pic_pkg::pic_cmd_t    cmd;
    pic_pkg::pic_status_t status;

    // sequencer: handshakes and command generation
    pic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // register file, scan unit and result register (held while stalled)
    pic_datapath #(
        .SOURCES (SOURCES)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .req_type           (req_type),
        .offset             (offset),
        .access_size        (access_size),
        .write_data         (write_data),
        .source_id          (source_id),
        .level              (level),
        .res_read_data      (read_data),
        .res_bus_fault      (bus_fault),
        .res_machine_irq    (machine_irq),
        .res_supervisor_irq (supervisor_irq)
    );

endmodule : platform_interrupt_controller_top

`default_nettype wire

[hdl/pic_checker.sv]
// ============================================================================
// pic_checker: port-level checks of the interrupt controller
// Bound to the top level.
// ============================================================================
`default_nettype none

module pic_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] read_data,
    input wire logic        bus_fault
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data))
        else $error("result word changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bus_fault |-> read_data == 32'd0)
        else $error("faulted access returned data");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken without result");

endmodule : pic_checker

bind platform_interrupt_controller_top pic_checker u_pic_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data),
    .bus_fault (bus_fault)
);

`default_nettype wire
